>>> sv/fkst_pkg.sv
// shared types and codes for the fingerprint keyed slot table
`default_nettype none

package fkst_pkg;

   // request word operation codes; the two codes above next mean nothing
   typedef enum logic [2:0] {
      MODE_FIND   = 3'd0,
      MODE_SAVE   = 3'd1,
      MODE_LOAD   = 3'd2,
      MODE_REMOVE = 3'd3,
      MODE_CLEAR  = 3'd4,
      MODE_NEXT   = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_MISS = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LOAD,
      ST_LOAD_DATA,
      ST_WRITE,
      ST_FINISH
   } state_type;

   localparam int KEY_BITS = 64;
   localparam int PAY_PORT_BITS = 32;
   localparam int HIT_BITS = 5;

endpackage

`default_nettype wire

>>> sv/fingerprint_keyed_slot_table.sv
// fingerprint keyed slot table: sequencer around a slot memory with one read and one write port and one key comparator
//
//   channel   direction  handshake             word
//   req_      in         req_valid / req_stall mode, key halves, payload, slot index, from_start
//   rsp_      out        rsp_valid / rsp_stall status, hit index, key halves, payload, slot valid
//
// find, save and next walk the slot memory one entry a cycle through one 128-bit comparator;
//   a save that finds its key or a free slot adds a write step
// load passes a read step and a data step, remove a write step, clear a clearing pass (one memory write per cycle)
// after reset a clearing pass zeroes every slot of the memory; no word is taken meanwhile
// a finished word waits in a staging register; a stalled result holds the block in its last step
`default_nettype none

module fingerprint_keyed_slot_table
   import fkst_pkg::*;
#(
   parameter int SLOT_COUNT = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [2:0]               req_mode,
   input  wire logic [KEY_BITS-1:0]      req_key_high,
   input  wire logic [KEY_BITS-1:0]      req_key_low,
   input  wire logic [PAY_PORT_BITS-1:0] req_payload_in,
   input  wire logic [HIT_BITS-1:0]      req_slot_index,
   input  wire logic                     req_from_start,

   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [HIT_BITS-1:0]           rsp_hit_index,
   output logic [KEY_BITS-1:0]           rsp_key_high_out,
   output logic [KEY_BITS-1:0]           rsp_key_low_out,
   output logic [PAY_PORT_BITS-1:0]      rsp_payload_out,
   output logic                          rsp_slot_valid
);

   localparam int STORE_BITS = (PAYLOAD_BITS < PAY_PORT_BITS) ? PAYLOAD_BITS : PAY_PORT_BITS;
   localparam int ENT_W = 1 + 2 * KEY_BITS + STORE_BITS;
   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(SLOT_COUNT);
   localparam logic [CNT_W-1:0] SLOT_LAST = CNT_W'(SLOT_COUNT - 1);

   // slot memory: {occupied, key high, key low, payload}
   logic [ENT_W-1:0] mem [SLOT_COUNT];
   logic [ENT_W-1:0] mem_rd_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] mem_raddr;
   logic [ENT_W-1:0] mem_wdata;

   logic                    rd_occ;
   logic [KEY_BITS-1:0]     rd_kh;
   logic [KEY_BITS-1:0]     rd_kl;
   logic [STORE_BITS-1:0]   rd_pay;
   logic                    key_eq;

   state_type state_ff, state_in;
   mode_type  op_ff, op_in;
   logic [KEY_BITS-1:0]   key_hi_ff, key_hi_in;
   logic [KEY_BITS-1:0]   key_lo_ff, key_lo_in;
   logic [STORE_BITS-1:0] pay_ff, pay_in;
   logic [HIT_BITS-1:0]   idx_ff, idx_in;

   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;

   status_type                res_status_ff, res_status_in;
   logic [HIT_BITS-1:0]       res_idx_ff, res_idx_in;
   logic [KEY_BITS-1:0]       res_kh_ff, res_kh_in;
   logic [KEY_BITS-1:0]       res_kl_ff, res_kl_in;
   logic [PAY_PORT_BITS-1:0]  res_pay_ff, res_pay_in;
   logic                      res_valid_ff, res_valid_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [HIT_BITS-1:0]       rsp_idx_ff, rsp_idx_in;
   logic [KEY_BITS-1:0]       rsp_kh_ff, rsp_kh_in;
   logic [KEY_BITS-1:0]       rsp_kl_ff, rsp_kl_in;
   logic [PAY_PORT_BITS-1:0]  rsp_pay_ff, rsp_pay_in;
   logic                      rsp_sv_ff, rsp_sv_in;

   assign rd_occ = mem_rd_ff[ENT_W-1];
   assign rd_kh  = mem_rd_ff[ENT_W-2 -: KEY_BITS];
   assign rd_kl  = mem_rd_ff[STORE_BITS +: KEY_BITS];
   assign rd_pay = mem_rd_ff[STORE_BITS-1:0];
   assign key_eq = (rd_kh == key_hi_ff) && (rd_kl == key_lo_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= mem[mem_raddr];
   end

   always_comb begin
      logic       stop;
      logic [5:0] next_start;

      stop          = 1'b0;
      next_start    = 6'(req_slot_index) + 6'd1;

      state_in      = state_ff;
      op_in         = op_ff;
      key_hi_in     = key_hi_ff;
      key_lo_in     = key_lo_ff;
      pay_in        = pay_ff;
      idx_in        = idx_ff;
      rd_cnt_in     = rd_cnt_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      wr_idx_in     = wr_idx_ff;

      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_kh_in     = res_kh_ff;
      res_kl_in     = res_kl_ff;
      res_pay_in    = res_pay_ff;
      res_valid_in  = res_valid_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_kh_in     = rsp_kh_ff;
      rsp_kl_in     = rsp_kl_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_sv_in     = rsp_sv_ff;

      mem_we        = 1'b0;
      mem_waddr     = wr_idx_ff;
      mem_wdata     = '0;
      mem_raddr     = rd_cnt_ff[IDX_W-1:0];

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = rd_cnt_ff[IDX_W-1:0];
            rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            if (rd_cnt_ff == SLOT_LAST) begin
               rd_cnt_in = '0;
               if (op_ff == MODE_CLEAR) begin
                  res_status_in = STAT_OK;
                  res_idx_in    = '0;
                  res_kh_in     = '0;
                  res_kl_in     = '0;
                  res_pay_in    = '0;
                  res_valid_in  = 1'b0;
                  state_in      = ST_FINISH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               op_in         = mode_type'(req_mode);
               key_hi_in     = req_key_high;
               key_lo_in     = req_key_low;
               pay_in        = STORE_BITS'(req_payload_in);
               idx_in        = req_slot_index;
               free_found_in = 1'b0;
               rd_cnt_in     = '0;
               // a miss word is the default answer; ops that go on overwrite it later
               res_status_in = STAT_MISS;
               res_idx_in    = '0;
               res_kh_in     = '0;
               res_kl_in     = '0;
               res_pay_in    = '0;
               res_valid_in  = 1'b0;
               case (mode_type'(req_mode))
                  MODE_FIND, MODE_SAVE: begin
                     state_in = ST_SCAN;
                  end
                  MODE_NEXT: begin
                     state_in = ST_SCAN;
                     if (req_from_start) begin
                        rd_cnt_in = '0;
                     end else if (32'(next_start) >= SLOT_COUNT) begin
                        rd_cnt_in = SLOT_END;
                     end else begin
                        rd_cnt_in = CNT_W'(next_start);
                     end
                  end
                  MODE_LOAD: begin
                     if (32'(req_slot_index) >= SLOT_COUNT) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_LOAD;
                     end
                  end
                  MODE_REMOVE: begin
                     if (32'(req_slot_index) >= SLOT_COUNT) begin
                        state_in = ST_FINISH;
                     end else begin
                        wr_idx_in = IDX_W'(req_slot_index);
                        state_in  = ST_WRITE;
                     end
                  end
                  MODE_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (rd_pend_ff) begin
               case (op_ff)
                  MODE_FIND, MODE_NEXT: begin
                     if (rd_occ && (key_eq || op_ff == MODE_NEXT)) begin
                        stop          = 1'b1;
                        res_status_in = STAT_OK;
                        res_idx_in    = HIT_BITS'(rd_idx_ff);
                        res_kh_in     = rd_kh;
                        res_kl_in     = rd_kl;
                        res_pay_in    = PAY_PORT_BITS'(rd_pay);
                        res_valid_in  = 1'b1;
                        state_in      = ST_FINISH;
                     end
                  end
                  MODE_SAVE: begin
                     if (rd_occ && key_eq) begin
                        stop      = 1'b1;
                        wr_idx_in = rd_idx_ff;
                        state_in  = ST_WRITE;
                     end else if (!rd_occ && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = rd_idx_ff;
                     end
                  end
                  default: begin
                     stop = 1'b0;
                  end
               endcase
            end
            if (!stop) begin
               if (rd_cnt_ff < SLOT_END) begin
                  rd_pend_in = 1'b1;
                  rd_idx_in  = rd_cnt_ff[IDX_W-1:0];
                  rd_cnt_in  = rd_cnt_ff + CNT_W'(1);
               end else if (!rd_pend_ff) begin
                  // table walked to its end without a hit
                  if (op_ff == MODE_SAVE && free_found_ff) begin
                     wr_idx_in = free_idx_ff;
                     state_in  = ST_WRITE;
                  end else begin
                     res_status_in = (op_ff == MODE_SAVE) ? STAT_FULL : STAT_MISS;
                     state_in      = ST_FINISH;
                  end
               end
            end
         end

         ST_LOAD: begin
            mem_raddr = IDX_W'(idx_ff);
            state_in  = ST_LOAD_DATA;
         end

         ST_LOAD_DATA: begin
            res_status_in = STAT_OK;
            res_idx_in    = idx_ff;
            res_kh_in     = rd_kh;
            res_kl_in     = rd_kl;
            res_pay_in    = PAY_PORT_BITS'(rd_pay);
            res_valid_in  = rd_occ;
            state_in      = ST_FINISH;
         end

         ST_WRITE: begin
            mem_we        = 1'b1;
            mem_waddr     = wr_idx_ff;
            res_status_in = STAT_OK;
            if (op_ff == MODE_SAVE) begin
               mem_wdata    = {1'b1, key_hi_ff, key_lo_ff, pay_ff};
               res_idx_in   = HIT_BITS'(wr_idx_ff);
               res_kh_in    = key_hi_ff;
               res_kl_in    = key_lo_ff;
               res_pay_in   = PAY_PORT_BITS'(pay_ff);
               res_valid_in = 1'b1;
            end else begin
               mem_wdata    = '0;
               res_idx_in   = idx_ff;
               res_kh_in    = '0;
               res_kl_in    = '0;
               res_pay_in   = '0;
               res_valid_in = 1'b0;
            end
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_kh_in     = res_kh_ff;
               rsp_kl_in     = res_kl_ff;
               rsp_pay_in    = res_pay_ff;
               rsp_sv_in     = res_valid_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         op_ff         <= MODE_FIND;
         rd_cnt_ff     <= '0;
         rd_pend_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         rd_cnt_ff     <= rd_cnt_in;
         rd_pend_ff    <= rd_pend_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_hi_ff     <= key_hi_in;
      key_lo_ff     <= key_lo_in;
      pay_ff        <= pay_in;
      idx_ff        <= idx_in;
      rd_idx_ff     <= rd_idx_in;
      free_idx_ff   <= free_idx_in;
      wr_idx_ff     <= wr_idx_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_kh_ff     <= res_kh_in;
      res_kl_ff     <= res_kl_in;
      res_pay_ff    <= res_pay_in;
      res_valid_ff  <= res_valid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_kh_ff     <= rsp_kh_in;
      rsp_kl_ff     <= rsp_kl_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_sv_ff     <= rsp_sv_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_hit_index    = rsp_idx_ff;
   assign rsp_key_high_out = rsp_kh_ff;
   assign rsp_key_low_out  = rsp_kl_ff;
   assign rsp_payload_out  = rsp_pay_ff;
   assign rsp_slot_valid   = rsp_sv_ff;

   // a failed word carries nothing but its status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |->
         rsp_hit_index == '0 && rsp_key_high_out == '0 && rsp_key_low_out == '0 &&
         rsp_payload_out == '0 && !rsp_slot_valid)
      else $error("failed result word carries data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slot_valid |-> rsp_status == STAT_OK)
      else $error("occupied slot reported with bad status");

   // the staged word must reach the output once the output side is free
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && (!rsp_valid_ff || !rsp_stall) |=>
         rsp_valid_ff && state_ff == ST_IDLE)
      else $error("staged result not handed to output");

   assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> 32'(rd_idx_ff) < SLOT_COUNT)
      else $error("scan read beyond table");

   // memory is written only by the clearing pass or a single write step
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == ST_CLEAR || state_ff == ST_WRITE)
      else $error("slot memory written outside a write step");

endmodule

`default_nettype wire
